[rtl/cpfw_pkg.sv]
// shared types and constants for the cylinder potential-flow wind block
package cpfw_pkg;

    // field widths
    localparam int POS_W     = 24;
    localparam int DIFF_W    = 25;
    localparam int SQ_W      = 49;
    localparam int R2SUM_W   = 50;
    localparam int SPEED_W   = 16;
    localparam int RADIUS_W  = 10;
    localparam int RR_W      = 20;
    localparam int VD_W      = 64;
    localparam int VDR_W     = 84;
    localparam int DEN_W     = 99;
    localparam int Q_BITS    = 22;
    localparam int DEN_SH_W  = DEN_W + Q_BITS - 1;
    localparam int TERM_W    = 21;
    localparam int WIND_W    = 16;
    localparam int SUM_W     = 23;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_NORTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_DOWN     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CYLINDER_RADIUS   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_STREAM_SPEED = 8'd3;

    // register reset values
    localparam logic signed [POS_W-1:0]   OBSTACLE_NORTH_RST    = 24'sd58880;
    localparam logic signed [POS_W-1:0]   OBSTACLE_DOWN_RST     = 24'sd0;
    localparam logic [RADIUS_W-1:0]       CYLINDER_RADIUS_RST   = 10'd50;
    localparam logic signed [SPEED_W-1:0] FREE_STREAM_SPEED_RST = -16'sd3072;

    // limits
    localparam logic [TERM_W-1:0]         TERM_LIMIT = 21'h100000;
    localparam logic signed [SUM_W-1:0]   NORTH_HI   = 23'sd32767;
    localparam logic signed [SUM_W-1:0]   WIND_LO    = -23'sd32768;
    localparam logic signed [SUM_W-1:0]   DOWN_HI    = 23'sd256;

    // per-item sideband carried down the pipeline
    typedef struct packed {
        logic                      zero;
        logic                      vneg;
        logic                      xneg;
        logic                      zneg;
        logic                      bbig;
        logic                      cap1;
        logic                      cap2;
        logic signed [SPEED_W-1:0] v;
    } side_t;

endpackage

[rtl/cpfw_intf.sv]
// channel interfaces: position in, wind out, configuration write
interface cpfw_pos_if;
    import cpfw_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] vehicle_north;
    logic signed [POS_W-1:0] vehicle_down;
    modport source (output valid, output vehicle_north, output vehicle_down, input ready);
    modport sink   (input valid, input vehicle_north, input vehicle_down, output ready);
endinterface

interface cpfw_wind_if;
    import cpfw_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [WIND_W-1:0] wind_north;
    logic signed [WIND_W-1:0] wind_down;
    logic                     at_centre;
    modport source (output valid, output wind_north, output wind_down, output at_centre,
                    input ready);
    modport sink   (input valid, input wind_north, input wind_down, input at_centre,
                    output ready);
endinterface

interface cpfw_cfg_if;
    import cpfw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/cylinder_potential_flow_wind.sv]
// top level: potential-flow wind around a cylinder, pipelined one position per cycle
//
//   channel | direction | carries
//   pos     | in        | vehicle_north, vehicle_down (Q15.8 m)
//   wind    | out       | wind_north, wind_down (Q7.8 m/s), at_centre
//   cfg     | in        | index, data: register writes, always ready
//
// one position per cycle while no result waits on wind.ready; 8 front stages,
// 22 divider cells of one quotient bit each, one output register
// the whole pipeline moves when the output register is empty or taken,
// so pos.ready drops only while a result waits on wind.ready
// reset clears all valid bits and loads the register defaults
module cylinder_potential_flow_wind
    import cpfw_pkg::*;
#(
    parameter int POS_FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    cpfw_pos_if.sink    pos,
    cpfw_wind_if.source wind,
    cpfw_cfg_if.sink    cfg
);

    localparam int NUM_W = 86 + 2 * POS_FRAC_BITS;
    localparam int REM_W = (NUM_W > DEN_SH_W + 1) ? NUM_W : DEN_SH_W + 1;

    logic signed [POS_W-1:0]   obstacle_north_reg;
    logic signed [POS_W-1:0]   obstacle_down_reg;
    logic [RADIUS_W-1:0]       cylinder_radius_reg;
    logic signed [SPEED_W-1:0] free_stream_speed_reg;
    logic                      adv;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_north_reg    <= OBSTACLE_NORTH_RST;
            obstacle_down_reg     <= OBSTACLE_DOWN_RST;
            cylinder_radius_reg   <= CYLINDER_RADIUS_RST;
            free_stream_speed_reg <= FREE_STREAM_SPEED_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_OBSTACLE_NORTH:    obstacle_north_reg    <= cfg.data;
                REG_OBSTACLE_DOWN:     obstacle_down_reg     <= cfg.data;
                REG_CYLINDER_RADIUS:   cylinder_radius_reg   <= cfg.data[RADIUS_W-1:0];
                REG_FREE_STREAM_SPEED: free_stream_speed_reg <= cfg.data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    assign adv       = !wind.valid || wind.ready;
    assign pos.ready = adv;

    // front stages
    logic                f_valid;
    side_t               f_side;
    logic [REM_W-1:0]    f_num1, f_num2;
    logic [DEN_SH_W-1:0] f_dsh;

    cpfw_front #(
        .POS_FRAC_BITS (POS_FRAC_BITS),
        .REM_W         (REM_W)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .in_valid          (pos.valid),
        .vehicle_north     (pos.vehicle_north),
        .vehicle_down      (pos.vehicle_down),
        .obstacle_north    (obstacle_north_reg),
        .obstacle_down     (obstacle_down_reg),
        .cylinder_radius   (cylinder_radius_reg),
        .free_stream_speed (free_stream_speed_reg),
        .out_valid         (f_valid),
        .out_side          (f_side),
        .num1              (f_num1),
        .num2              (f_num2),
        .dsh               (f_dsh)
    );

    // divider chain
    logic                c_valid [0:Q_BITS];
    side_t               c_side  [0:Q_BITS];
    logic [REM_W-1:0]    c_rem1  [0:Q_BITS];
    logic [REM_W-1:0]    c_rem2  [0:Q_BITS];
    logic [DEN_SH_W-1:0] c_dsh   [0:Q_BITS];
    logic [Q_BITS-1:0]   c_q1    [0:Q_BITS];
    logic [Q_BITS-1:0]   c_q2    [0:Q_BITS];

    assign c_valid[0] = f_valid;
    assign c_side[0]  = f_side;
    assign c_rem1[0]  = f_num1;
    assign c_rem2[0]  = f_num2;
    assign c_dsh[0]   = f_dsh;
    assign c_q1[0]    = '0;
    assign c_q2[0]    = '0;

    for (genvar i = 0; i < Q_BITS; i++)
    begin : g_cell
        cpfw_div_cell #(
            .REM_W (REM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (c_valid[i]),
            .in_side   (c_side[i]),
            .in_rem1   (c_rem1[i]),
            .in_rem2   (c_rem2[i]),
            .in_dsh    (c_dsh[i]),
            .in_q1     (c_q1[i]),
            .in_q2     (c_q2[i]),
            .out_valid (c_valid[i+1]),
            .out_side  (c_side[i+1]),
            .out_rem1  (c_rem1[i+1]),
            .out_rem2  (c_rem2[i+1]),
            .out_dsh   (c_dsh[i+1]),
            .out_q1    (c_q1[i+1]),
            .out_q2    (c_q2[i+1])
        );
    end

    // rounding and output register
    cpfw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (c_valid[Q_BITS]),
        .in_side    (c_side[Q_BITS]),
        .in_q1      (c_q1[Q_BITS]),
        .in_q2      (c_q2[Q_BITS]),
        .out_valid  (wind.valid),
        .wind_north (wind.wind_north),
        .wind_down  (wind.wind_down),
        .at_centre  (wind.at_centre)
    );

endmodule

[rtl/cpfw_front.sv]
// front pipeline: offsets, squares, split products, numerators and divisor
module cpfw_front
    import cpfw_pkg::*;
#(
    parameter int POS_FRAC_BITS = 8,
    parameter int REM_W         = 121
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic signed [POS_W-1:0]    vehicle_north,
    input  logic signed [POS_W-1:0]    vehicle_down,
    input  logic signed [POS_W-1:0]    obstacle_north,
    input  logic signed [POS_W-1:0]    obstacle_down,
    input  logic [RADIUS_W-1:0]        cylinder_radius,
    input  logic signed [SPEED_W-1:0]  free_stream_speed,
    output logic                       out_valid,
    output side_t                      out_side,
    output logic [REM_W-1:0]           num1,
    output logic [REM_W-1:0]           num2,
    output logic [DEN_SH_W-1:0]        dsh
);

    logic [7:0] vld_reg;

    // stage 1: offsets and magnitudes
    logic signed [DIFF_W-1:0] dx_next, dz_next;
    logic [DIFF_W-1:0]        a_next, b_next;
    side_t                    s1_side_next;
    logic [DIFF_W-1:0]        s1_a_reg, s1_b_reg;
    side_t                    s1_side_reg;

    assign dx_next = DIFF_W'(obstacle_north) - DIFF_W'(vehicle_north);
    assign dz_next = DIFF_W'(obstacle_down) - DIFF_W'(vehicle_down);
    assign a_next  = dx_next[DIFF_W-1] ? DIFF_W'(-dx_next) : DIFF_W'(dx_next);
    assign b_next  = dz_next[DIFF_W-1] ? DIFF_W'(-dz_next) : DIFF_W'(dz_next);

    always_comb
    begin
        s1_side_next      = '0;
        s1_side_next.zero = (dx_next == '0) && (dz_next == '0);
        s1_side_next.vneg = free_stream_speed[SPEED_W-1];
        s1_side_next.xneg = dx_next[DIFF_W-1];
        s1_side_next.zneg = dz_next[DIFF_W-1];
        s1_side_next.v    = free_stream_speed;
    end

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg    <= a_next;
            s1_b_reg    <= b_next;
            s1_side_reg <= s1_side_next;
        end
    end

    // stage 2: squares and cross product
    logic [2*DIFF_W-1:0] a2_full, b2_full, ab_full;
    logic [SQ_W-1:0]     s2_a2_reg, s2_b2_reg, s2_ab_reg;
    side_t               s2_side_reg;

    assign a2_full = {{DIFF_W{1'b0}}, s1_a_reg} * {{DIFF_W{1'b0}}, s1_a_reg};
    assign b2_full = {{DIFF_W{1'b0}}, s1_b_reg} * {{DIFF_W{1'b0}}, s1_b_reg};
    assign ab_full = {{DIFF_W{1'b0}}, s1_a_reg} * {{DIFF_W{1'b0}}, s1_b_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_a2_reg   <= a2_full[SQ_W-1:0];
            s2_b2_reg   <= b2_full[SQ_W-1:0];
            s2_ab_reg   <= ab_full[SQ_W-1:0];
            s2_side_reg <= s1_side_reg;
        end
    end

    // stage 3: r^2 and the difference of squares
    logic [R2SUM_W-1:0] r2_next;
    logic [SQ_W-1:0]    dm_next;
    logic               bbig_next;
    side_t              s3_side_next;
    logic [R2SUM_W-1:0] s3_r2_reg;
    logic [SQ_W-1:0]    s3_dm_reg, s3_ab_reg;
    side_t              s3_side_reg;

    assign r2_next   = {1'b0, s2_a2_reg} + {1'b0, s2_b2_reg};
    assign bbig_next = s2_a2_reg < s2_b2_reg;
    assign dm_next   = bbig_next ? (s2_b2_reg - s2_a2_reg) : (s2_a2_reg - s2_b2_reg);

    always_comb
    begin
        s3_side_next      = s2_side_reg;
        s3_side_next.bbig = bbig_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_r2_reg   <= r2_next;
            s3_dm_reg   <= dm_next;
            s3_ab_reg   <= s2_ab_reg;
            s3_side_reg <= s3_side_next;
        end
    end

    // stage 4: partial products of r^4, v*dm and v*ab
    logic [SPEED_W-1:0] vm;
    logic [24:0]        rh, rl;
    logic [49:0]        hh_next, hl_next, ll_next;
    logic [39:0]        vdh_next, vabh_next;
    logic [40:0]        vdl_next, vabl_next;
    logic [49:0]        s4_hh_reg, s4_hl_reg, s4_ll_reg;
    logic [39:0]        s4_vdh_reg, s4_vabh_reg;
    logic [40:0]        s4_vdl_reg, s4_vabl_reg;
    side_t              s4_side_reg;

    assign vm = s3_side_reg.v[SPEED_W-1] ? SPEED_W'(-s3_side_reg.v) : SPEED_W'(s3_side_reg.v);
    assign rh = s3_r2_reg[49:25];
    assign rl = s3_r2_reg[24:0];
    assign hh_next   = {25'b0, rh} * {25'b0, rh};
    assign hl_next   = {25'b0, rh} * {25'b0, rl};
    assign ll_next   = {25'b0, rl} * {25'b0, rl};
    assign vdh_next  = {24'b0, vm} * {16'b0, s3_dm_reg[48:25]};
    assign vdl_next  = {25'b0, vm} * {16'b0, s3_dm_reg[24:0]};
    assign vabh_next = {24'b0, vm} * {16'b0, s3_ab_reg[48:25]};
    assign vabl_next = {25'b0, vm} * {16'b0, s3_ab_reg[24:0]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_hh_reg   <= hh_next;
            s4_hl_reg   <= hl_next;
            s4_ll_reg   <= ll_next;
            s4_vdh_reg  <= vdh_next;
            s4_vdl_reg  <= vdl_next;
            s4_vabh_reg <= vabh_next;
            s4_vabl_reg <= vabl_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    // stage 5: sum partial products
    logic [99:0]       den_full;
    logic [VD_W-1:0]   vd_next, vab_next;
    logic [DEN_W-1:0]  s5_den_reg;
    logic [VD_W-1:0]   s5_vd_reg, s5_vab_reg;
    side_t             s5_side_reg;

    assign den_full = ({50'b0, s4_hh_reg} << 50) + ({50'b0, s4_hl_reg} << 26)
                    + {50'b0, s4_ll_reg};
    assign vd_next  = ({24'b0, s4_vdh_reg} << 25) + {23'b0, s4_vdl_reg};
    assign vab_next = ({24'b0, s4_vabh_reg} << 25) + {23'b0, s4_vabl_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_den_reg  <= den_full[DEN_W-1:0];
            s5_vd_reg   <= vd_next;
            s5_vab_reg  <= vab_next;
            s5_side_reg <= s4_side_reg;
        end
    end

    // stage 6: scale by radius squared, split in halves
    logic [RR_W-1:0]   rr;
    logic [51:0]       vdrh_next, vdrl_next, vabrh_next, vabrl_next;
    logic [51:0]       s6_vdrh_reg, s6_vdrl_reg, s6_vabrh_reg, s6_vabrl_reg;
    logic [DEN_W-1:0]  s6_den_reg;
    side_t             s6_side_reg;

    assign rr         = {10'b0, cylinder_radius} * {10'b0, cylinder_radius};
    assign vdrh_next  = {20'b0, s5_vd_reg[63:32]}  * {32'b0, rr};
    assign vdrl_next  = {20'b0, s5_vd_reg[31:0]}   * {32'b0, rr};
    assign vabrh_next = {20'b0, s5_vab_reg[63:32]} * {32'b0, rr};
    assign vabrl_next = {20'b0, s5_vab_reg[31:0]}  * {32'b0, rr};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_vdrh_reg  <= vdrh_next;
            s6_vdrl_reg  <= vdrl_next;
            s6_vabrh_reg <= vabrh_next;
            s6_vabrl_reg <= vabrl_next;
            s6_den_reg   <= s5_den_reg;
            s6_side_reg  <= s5_side_reg;
        end
    end

    // stage 7: numerators in units of half a Q7.8 step, divisor aligned to the top bit
    logic [VDR_W-1:0]    vdr, vabr;
    logic [REM_W-1:0]    s7_n1_reg, s7_n2_reg;
    logic [DEN_SH_W-1:0] s7_d_reg;
    side_t               s7_side_reg;

    assign vdr  = ({32'b0, s6_vdrh_reg} << 32) + {32'b0, s6_vdrl_reg};
    assign vabr = ({32'b0, s6_vabrh_reg} << 32) + {32'b0, s6_vabrl_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_n1_reg   <= REM_W'(vdr) << (2 * POS_FRAC_BITS + 1);
            s7_n2_reg   <= REM_W'(vabr) << (2 * POS_FRAC_BITS + 2);
            s7_d_reg    <= DEN_SH_W'(s6_den_reg) << (Q_BITS - 1);
            s7_side_reg <= s6_side_reg;
        end
    end

    // stage 8: quotient overflow check
    logic [REM_W-1:0] d2;
    side_t            s8_side_next;
    side_t            s8_side_reg;
    logic [REM_W-1:0] s8_n1_reg, s8_n2_reg;
    logic [DEN_SH_W-1:0] s8_d_reg;

    assign d2 = REM_W'({s7_d_reg, 1'b0});

    always_comb
    begin
        s8_side_next      = s7_side_reg;
        s8_side_next.cap1 = s7_n1_reg >= d2;
        s8_side_next.cap2 = s7_n2_reg >= d2;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_n1_reg   <= s7_n1_reg;
            s8_n2_reg   <= s7_n2_reg;
            s8_d_reg    <= s7_d_reg;
            s8_side_reg <= s8_side_next;
        end
    end

    assign out_valid = vld_reg[7];
    assign out_side  = s8_side_reg;
    assign num1      = s8_n1_reg;
    assign num2      = s8_n2_reg;
    assign dsh       = s8_d_reg;

endmodule

[rtl/cpfw_div_cell.sv]
// one divider cell: a quotient bit for both terms, passes remainders on
module cpfw_div_cell
    import cpfw_pkg::*;
#(
    parameter int REM_W = 121
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  side_t               in_side,
    input  logic [REM_W-1:0]    in_rem1,
    input  logic [REM_W-1:0]    in_rem2,
    input  logic [DEN_SH_W-1:0] in_dsh,
    input  logic [Q_BITS-1:0]   in_q1,
    input  logic [Q_BITS-1:0]   in_q2,
    output logic                out_valid,
    output side_t               out_side,
    output logic [REM_W-1:0]    out_rem1,
    output logic [REM_W-1:0]    out_rem2,
    output logic [DEN_SH_W-1:0] out_dsh,
    output logic [Q_BITS-1:0]   out_q1,
    output logic [Q_BITS-1:0]   out_q2
);

    logic [REM_W-1:0] dext;
    logic             ge1, ge2;
    logic [REM_W-1:0] r1_next, r2_next;
    logic             valid_reg;

    // compare and subtract the aligned divisor
    assign dext    = REM_W'(in_dsh);
    assign ge1     = in_rem1 >= dext;
    assign ge2     = in_rem2 >= dext;
    assign r1_next = ge1 ? (in_rem1 - dext) : in_rem1;
    assign r2_next = ge2 ? (in_rem2 - dext) : in_rem2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_side <= in_side;
            out_rem1 <= r1_next << 1;
            out_rem2 <= r2_next << 1;
            out_dsh  <= in_dsh;
            out_q1   <= {in_q1[Q_BITS-2:0], ge1};
            out_q2   <= {in_q2[Q_BITS-2:0], ge2};
        end
    end

    assign out_valid = valid_reg;

endmodule

[rtl/cpfw_back.sv]
// rounding, sign, saturation and the output register
module cpfw_back
    import cpfw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  side_t                     in_side,
    input  logic [Q_BITS-1:0]         in_q1,
    input  logic [Q_BITS-1:0]         in_q2,
    output logic                      out_valid,
    output logic signed [WIND_W-1:0]  wind_north,
    output logic signed [WIND_W-1:0]  wind_down,
    output logic                      at_centre
);

    // half-step quotient to rounded, capped term
    function automatic logic [TERM_W-1:0] round_cap(input logic [Q_BITS-1:0] q,
                                                    input logic cap);
        logic [Q_BITS:0]   qp;
        logic [Q_BITS-1:0] qh;
        qp = {1'b0, q} + {{Q_BITS{1'b0}}, 1'b1};
        qh = qp[Q_BITS:1];
        if (cap || (qh > Q_BITS'(TERM_LIMIT)))
        begin
            return TERM_LIMIT;
        end
        return qh[TERM_W-1:0];
    endfunction

    logic [TERM_W-1:0]        t1, t2;
    logic signed [SUM_W-1:0]  ext_v, ext_t1, ext_t2, nsum, dsum;
    logic signed [WIND_W-1:0] north_next, down_next;
    logic                     neg1, neg2;
    logic                     valid_reg;

    assign t1     = round_cap(in_q1, in_side.cap1);
    assign t2     = round_cap(in_q2, in_side.cap2);
    assign ext_v  = SUM_W'(in_side.v);
    assign ext_t1 = {2'b0, t1};
    assign ext_t2 = {2'b0, t2};
    assign neg1   = in_side.vneg ^ in_side.bbig;
    assign neg2   = in_side.vneg ^ in_side.xneg ^ in_side.zneg;
    assign nsum   = neg1 ? (ext_v + ext_t1) : (ext_v - ext_t1);
    assign dsum   = neg2 ? ext_t2 : -ext_t2;

    // saturate both components, zero offset forces zero
    always_comb
    begin
        if (in_side.zero)
        begin
            north_next = '0;
            down_next  = '0;
        end
        else
        begin
            if (nsum > NORTH_HI)
                north_next = 16'sh7FFF;
            else if (nsum < WIND_LO)
                north_next = 16'sh8000;
            else
                north_next = nsum[WIND_W-1:0];
            if (dsum > DOWN_HI)
                down_next = DOWN_HI[WIND_W-1:0];
            else if (dsum < WIND_LO)
                down_next = 16'sh8000;
            else
                down_next = dsum[WIND_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wind_north <= north_next;
            wind_down  <= down_next;
            at_centre  <= in_side.zero;
        end
    end

    assign out_valid = valid_reg;

endmodule

[rtl/cpfw_checker.sv]
// port-level checks for the wind block, bound to the top level
module cpfw_checker
    import cpfw_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     pos_ready,
    input logic                     wind_valid,
    input logic                     wind_ready,
    input logic signed [WIND_W-1:0] wind_north,
    input logic signed [WIND_W-1:0] wind_down,
    input logic                     at_centre
);

    // a waiting result holds until its transfer
    a_wind_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wind_valid && !wind_ready |=> wind_valid && $stable(wind_north)
            && $stable(wind_down) && $stable(at_centre))
        else $error("wind result changed while stalled");

    // input stalls only behind a blocked result
    a_pos_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pos_ready |-> wind_valid && !wind_ready)
        else $error("input stalled without output back-pressure");

    // zero offset forces both components to zero
    a_centre: assert property (@(posedge clk) disable iff (!rst_n)
        wind_valid && at_centre |-> wind_north == '0 && wind_down == '0)
        else $error("nonzero wind at centre");

    // downward clamp
    a_down_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        wind_valid |-> wind_down <= 16'sd256)
        else $error("wind_down above clamp");

endmodule

bind cylinder_potential_flow_wind cpfw_checker u_cpfw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pos_ready  (pos.ready),
    .wind_valid (wind.valid),
    .wind_ready (wind.ready),
    .wind_north (wind.wind_north),
    .wind_down  (wind.wind_down),
    .at_centre  (wind.at_centre)
);
